// File: hdl/nsc_pkg.sv
// ----------------------------------------------------------------------------
// nsc_pkg
// Shared widths and codes for the nearest segment collision block.
// ----------------------------------------------------------------------------
package nsc_pkg;

  localparam int COORD_W = 20;
  localparam int DIFF_W  = COORD_W + 1;       // coordinate difference
  localparam int CPROD_W = 2 * COORD_W + 2;   // line constant C
  localparam int DET_W   = 2 * COORD_W + 3;   // determinant, also squared dist
  localparam int ACC_W   = 64;                // accumulator of the serial MAC
  localparam int QMAG_W  = ACC_W - 1;         // numerator magnitude bits
  localparam int OUTL_W  = 8;
  localparam int IDX_W   = 8;

  localparam int MAC_CNT_W = $clog2(DIFF_W);
  localparam int DIV_CNT_W = $clog2(QMAG_W);

  localparam logic [OUTL_W-1:0] OUTL_MAX = OUTL_W'(255);

  // configuration register indexes
  localparam logic [IDX_W-1:0] REG_START_X = IDX_W'(0);
  localparam logic [IDX_W-1:0] REG_START_Y = IDX_W'(1);
  localparam logic [IDX_W-1:0] REG_END_X   = IDX_W'(2);
  localparam logic [IDX_W-1:0] REG_END_Y   = IDX_W'(3);

  // MAC program steps
  localparam logic [3:0] STP_C1A = 4'd0;
  localparam logic [3:0] STP_C1B = 4'd1;
  localparam logic [3:0] STP_C2A = 4'd2;
  localparam logic [3:0] STP_C2B = 4'd3;
  localparam logic [3:0] STP_DTA = 4'd4;
  localparam logic [3:0] STP_DTB = 4'd5;
  localparam logic [3:0] STP_NXA = 4'd6;
  localparam logic [3:0] STP_NXB = 4'd7;
  localparam logic [3:0] STP_NYA = 4'd8;
  localparam logic [3:0] STP_NYB = 4'd9;
  localparam logic [3:0] STP_D2A = 4'd10;
  localparam logic [3:0] STP_D2B = 4'd11;

  typedef struct packed {
    logic start;
    logic clear;
    logic neg;
  } mac_ctl_t;

endpackage

// File: hdl/nearest_segment_collision.sv
// ----------------------------------------------------------------------------
// nearest_segment_collision
// Intersects each outline edge with the path and keeps the nearest hit.
// ----------------------------------------------------------------------------
// A vertex that closes no edge goes straight to the finish state. One that closes
// an edge runs 21-bit serial multiplies on the shared MAC (six up to the
// determinant, twelve for a hit) and, unless the lines are parallel, two 63-bit
// serial divisions. One vertex in flight: a new one is taken only when idle, and a
// final vertex also waits for the previous result. Reset: synchronous, clears the
// control state, configuration and best hit, not the datapath registers.
module nearest_segment_collision (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [nsc_pkg::IDX_W-1:0]            cfg_index,
  input  logic [nsc_pkg::COORD_W-1:0]          cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [nsc_pkg::COORD_W-1:0]   vertex_x,
  input  logic signed [nsc_pkg::COORD_W-1:0]   vertex_y,
  input  logic                                 outline_begin,
  input  logic                                 final_vertex,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic                                 collision_found,
  output logic signed [nsc_pkg::COORD_W-1:0]   collision_x,
  output logic signed [nsc_pkg::COORD_W-1:0]   collision_y,
  output logic [nsc_pkg::OUTL_W-1:0]           collision_outline
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_MUL   = 3'd1;
  localparam logic [2:0] S_MWAIT = 3'd2;
  localparam logic [2:0] S_DIV   = 3'd3;
  localparam logic [2:0] S_DWAIT = 3'd4;
  localparam logic [2:0] S_CHECK = 3'd5;
  localparam logic [2:0] S_FIN   = 3'd6;

  localparam int CW = nsc_pkg::COORD_W;

  logic [2:0] state;
  logic [3:0] step;
  logic       dsel;

  logic signed [CW-1:0] sx, sy, ex, ey;
  logic signed [CW-1:0] x1, y1, x2, y2;
  logic                 last;
  logic signed [CW-1:0] prev_x, prev_y;
  logic                 prev_valid;
  logic [nsc_pkg::OUTL_W-1:0] outline_count;
  logic [nsc_pkg::DET_W-1:0]  best_d2;
  logic signed [CW-1:0] best_x, best_y;
  logic [nsc_pkg::OUTL_W-1:0] best_outline;
  logic                 hit_seen;

  logic signed [nsc_pkg::CPROD_W-1:0] c1, c2;
  logic signed [nsc_pkg::DET_W-1:0]   det;
  logic signed [nsc_pkg::ACC_W-1:0]   nx, ny, ix;
  logic signed [CW-1:0]               hx, hy;

  logic signed [nsc_pkg::DIFF_W-1:0] a1, b1, a2, b2, dx, dy;
  logic signed [nsc_pkg::DIFF_W-1:0] mplier;
  logic signed [nsc_pkg::ACC_W-1:0]  mcand;
  nsc_pkg::mac_ctl_t                 mac_ctl;
  logic                              mac_busy;
  logic signed [nsc_pkg::ACC_W-1:0]  acc;
  logic                              div_start;
  logic                              div_busy;
  logic signed [nsc_pkg::ACC_W-1:0]  quo;

  logic                 fit_x, fit_y, in_box;
  logic signed [CW-1:0] qx, qy;
  logic [nsc_pkg::DET_W-1:0] d2;

  assign a1 = nsc_pkg::DIFF_W'(ey) - nsc_pkg::DIFF_W'(sy);
  assign b1 = nsc_pkg::DIFF_W'(sx) - nsc_pkg::DIFF_W'(ex);
  assign a2 = nsc_pkg::DIFF_W'(y2) - nsc_pkg::DIFF_W'(y1);
  assign b2 = nsc_pkg::DIFF_W'(x1) - nsc_pkg::DIFF_W'(x2);
  assign dx = nsc_pkg::DIFF_W'(hx) - nsc_pkg::DIFF_W'(sx);
  assign dy = nsc_pkg::DIFF_W'(hy) - nsc_pkg::DIFF_W'(sy);

  always_comb begin
    mplier = a1;
    mcand  = nsc_pkg::ACC_W'(sx);
    case (step)
      nsc_pkg::STP_C1A: begin mplier = a1; mcand = nsc_pkg::ACC_W'(sx); end
      nsc_pkg::STP_C1B: begin mplier = b1; mcand = nsc_pkg::ACC_W'(sy); end
      nsc_pkg::STP_C2A: begin mplier = a2; mcand = nsc_pkg::ACC_W'(x1); end
      nsc_pkg::STP_C2B: begin mplier = b2; mcand = nsc_pkg::ACC_W'(y1); end
      nsc_pkg::STP_DTA: begin mplier = a1; mcand = nsc_pkg::ACC_W'(b2); end
      nsc_pkg::STP_DTB: begin mplier = a2; mcand = nsc_pkg::ACC_W'(b1); end
      nsc_pkg::STP_NXA: begin mplier = b2; mcand = nsc_pkg::ACC_W'(c1); end
      nsc_pkg::STP_NXB: begin mplier = b1; mcand = nsc_pkg::ACC_W'(c2); end
      nsc_pkg::STP_NYA: begin mplier = a1; mcand = nsc_pkg::ACC_W'(c2); end
      nsc_pkg::STP_NYB: begin mplier = a2; mcand = nsc_pkg::ACC_W'(c1); end
      nsc_pkg::STP_D2A: begin mplier = dx; mcand = nsc_pkg::ACC_W'(dx); end
      nsc_pkg::STP_D2B: begin mplier = dy; mcand = nsc_pkg::ACC_W'(dy); end
      default: begin mplier = a1; mcand = nsc_pkg::ACC_W'(sx); end
    endcase
  end

  assign mac_ctl.start = (state == S_MUL);
  assign mac_ctl.clear = ~step[0];
  assign mac_ctl.neg   = (step == nsc_pkg::STP_DTB) || (step == nsc_pkg::STP_NXB) ||
                         (step == nsc_pkg::STP_NYB);
  assign div_start     = (state == S_DIV);

  nsc_mac u_mac (
    .clk    (clk),
    .rst    (rst),
    .ctl    (mac_ctl),
    .mcand  (mcand),
    .mplier (mplier),
    .busy   (mac_busy),
    .acc    (acc)
  );

  nsc_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (dsel ? ny : nx),
    .den   (det),
    .busy  (div_busy),
    .quo   (quo)
  );

  // quotients outside the coordinate range can never lie in a box
  assign fit_x = (&ix[nsc_pkg::ACC_W-1:CW-1]) | ~(|ix[nsc_pkg::ACC_W-1:CW-1]);
  assign fit_y = (&quo[nsc_pkg::ACC_W-1:CW-1]) | ~(|quo[nsc_pkg::ACC_W-1:CW-1]);
  assign qx    = ix[CW-1:0];
  assign qy    = quo[CW-1:0];
  assign in_box = fit_x && fit_y &&
                  ((qx >= x1 && qx <= x2) || (qx >= x2 && qx <= x1)) &&
                  ((qy >= y1 && qy <= y2) || (qy >= y2 && qy <= y1)) &&
                  ((qx >= sx && qx <= ex) || (qx >= ex && qx <= sx)) &&
                  ((qy >= sy && qy <= ey) || (qy >= ey && qy <= sy));
  assign d2 = acc[nsc_pkg::DET_W-1:0];

  assign in_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      sx <= '0;
      sy <= '0;
      ex <= '0;
      ey <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        nsc_pkg::REG_START_X: sx <= cfg_data;
        nsc_pkg::REG_START_Y: sy <= cfg_data;
        nsc_pkg::REG_END_X:   ex <= cfg_data;
        nsc_pkg::REG_END_Y:   ey <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      step          <= '0;
      dsel          <= 1'b0;
      prev_x        <= '0;
      prev_y        <= '0;
      prev_valid    <= 1'b0;
      outline_count <= '0;
      best_d2       <= '0;
      best_x        <= '0;
      best_y        <= '0;
      best_outline  <= '0;
      hit_seen      <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      // a new result loaded in S_FIN takes precedence over the drain
      if (out_valid && out_ready && !(state == S_FIN && last)) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            x1   <= prev_x;
            y1   <= prev_y;
            x2   <= vertex_x;
            y2   <= vertex_y;
            last <= final_vertex;
            step <= nsc_pkg::STP_C1A;
            if (outline_begin) begin
              prev_valid <= 1'b0;
              if (prev_valid && outline_count < nsc_pkg::OUTL_MAX) begin
                outline_count <= outline_count + 1'b1;
              end
            end
            state <= (prev_valid && !outline_begin) ? S_MUL : S_FIN;
          end
        end
        S_MUL: state <= S_MWAIT;
        S_MWAIT: begin
          if (!mac_busy) begin
            step  <= step + 1'b1;
            state <= S_MUL;
            case (step)
              nsc_pkg::STP_C1B: c1 <= acc[nsc_pkg::CPROD_W-1:0];
              nsc_pkg::STP_C2B: c2 <= acc[nsc_pkg::CPROD_W-1:0];
              nsc_pkg::STP_DTB: begin
                det <= acc[nsc_pkg::DET_W-1:0];
                if (acc == '0) begin
                  state <= S_FIN;
                end
              end
              nsc_pkg::STP_NXB: nx <= acc;
              nsc_pkg::STP_NYB: begin
                ny    <= acc;
                dsel  <= 1'b0;
                state <= S_DIV;
              end
              nsc_pkg::STP_D2B: begin
                if (!hit_seen || d2 < best_d2) begin
                  hit_seen     <= 1'b1;
                  best_d2      <= d2;
                  best_x       <= hx;
                  best_y       <= hy;
                  best_outline <= outline_count;
                end
                state <= S_FIN;
              end
              default: ;
            endcase
          end
        end
        S_DIV: state <= S_DWAIT;
        S_DWAIT: begin
          if (!div_busy) begin
            if (!dsel) begin
              ix    <= quo;
              dsel  <= 1'b1;
              state <= S_DIV;
            end else begin
              state <= S_CHECK;
            end
          end
        end
        S_CHECK: begin
          hx <= qx;
          hy <= qy;
          if (in_box) begin
            step  <= nsc_pkg::STP_D2A;
            state <= S_MUL;
          end else begin
            state <= S_FIN;
          end
        end
        S_FIN: begin
          if (!last) begin
            prev_x     <= x2;
            prev_y     <= y2;
            prev_valid <= 1'b1;
            state      <= S_IDLE;
          end else if (!out_valid || out_ready) begin
            out_valid         <= 1'b1;
            collision_found   <= hit_seen;
            collision_x       <= hit_seen ? best_x : '0;
            collision_y       <= hit_seen ? best_y : '0;
            collision_outline <= hit_seen ? best_outline : '0;
            prev_x        <= '0;
            prev_y        <= '0;
            prev_valid    <= 1'b0;
            outline_count <= '0;
            best_d2       <= '0;
            best_x        <= '0;
            best_y        <= '0;
            best_outline  <= '0;
            hit_seen      <= 1'b0;
            state         <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_units_exclusive: assert property (@(posedge clk) disable iff (rst)
    !(mac_busy && div_busy))
    else $error("MAC and divider busy together");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> state != S_IDLE)
    else $error("item accepted but control stayed idle");

  a_miss_is_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !collision_found |->
      collision_x == '0 && collision_y == '0 && collision_outline == '0)
    else $error("miss reported with nonzero payload");

endmodule

// File: hdl/nsc_mac.sv
// ----------------------------------------------------------------------------
// nsc_mac
// Bit-serial signed multiply-accumulate, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module nsc_mac (
  input  logic                                clk,
  input  logic                                rst,
  input  nsc_pkg::mac_ctl_t                   ctl,
  input  logic signed [nsc_pkg::ACC_W-1:0]    mcand,
  input  logic signed [nsc_pkg::DIFF_W-1:0]   mplier,
  output logic                                busy,
  output logic signed [nsc_pkg::ACC_W-1:0]    acc
);

  logic signed [nsc_pkg::ACC_W-1:0]     mc;
  logic        [nsc_pkg::DIFF_W-1:0]    mp;
  logic        [nsc_pkg::MAC_CNT_W-1:0] cnt;
  logic                                 neg;
  logic        [nsc_pkg::ACC_W-1:0]     term;
  logic                                 last;
  logic                                 sub;

  assign last = (cnt == nsc_pkg::MAC_CNT_W'(nsc_pkg::DIFF_W - 1));
  assign term = mp[0] ? mc : '0;
  assign sub  = last ^ neg;   // msb of the multiplier weighs negative

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (ctl.start) begin
      busy <= 1'b1;
      cnt  <= '0;
      if (ctl.clear) begin
        acc <= '0;
      end
      mc  <= mcand;
      mp  <= mplier;
      neg <= ctl.neg;
    end else if (busy) begin
      acc <= sub ? acc - term : acc + term;
      mc  <= mc <<< 1;
      mp  <= mp >> 1;
      cnt <= cnt + 1'b1;
      if (last) begin
        busy <= 1'b0;
      end
    end
  end

endmodule

// File: hdl/nsc_div.sv
// ----------------------------------------------------------------------------
// nsc_div
// Restoring signed divider, one quotient bit per cycle, truncates toward zero.
// ----------------------------------------------------------------------------
module nsc_div (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  input  logic signed [nsc_pkg::ACC_W-1:0]   num,
  input  logic signed [nsc_pkg::DET_W-1:0]   den,
  output logic                               busy,
  output logic signed [nsc_pkg::ACC_W-1:0]   quo
);

  logic [nsc_pkg::QMAG_W-1:0]    n;
  logic [nsc_pkg::QMAG_W-1:0]    q;
  logic [nsc_pkg::DET_W-1:0]     d;
  logic [nsc_pkg::DET_W-1:0]     rem;
  logic [nsc_pkg::DET_W:0]       rem_sh;
  logic [nsc_pkg::DET_W:0]       rem_sub;
  logic                          qbit;
  logic                          neg;
  logic [nsc_pkg::DIV_CNT_W-1:0] cnt;
  logic [nsc_pkg::ACC_W-1:0]     num_abs;
  logic [nsc_pkg::DET_W-1:0]     den_abs;

  assign num_abs = num[nsc_pkg::ACC_W-1] ? -num : num;
  assign den_abs = den[nsc_pkg::DET_W-1] ? -den : den;
  assign rem_sh  = {rem, n[nsc_pkg::QMAG_W-1]};
  assign rem_sub = rem_sh - {1'b0, d};
  assign qbit    = ~rem_sub[nsc_pkg::DET_W];
  assign quo     = neg ? -{1'b0, q} : {1'b0, q};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= '0;
      n    <= num_abs[nsc_pkg::QMAG_W-1:0];
      d    <= den_abs;
      rem  <= '0;
      q    <= '0;
      neg  <= num[nsc_pkg::ACC_W-1] ^ den[nsc_pkg::DET_W-1];
    end else if (busy) begin
      rem <= qbit ? rem_sub[nsc_pkg::DET_W-1:0] : rem_sh[nsc_pkg::DET_W-1:0];
      q   <= {q[nsc_pkg::QMAG_W-2:0], qbit};
      n   <= n << 1;
      cnt <= cnt + 1'b1;
      if (cnt == nsc_pkg::DIV_CNT_W'(nsc_pkg::QMAG_W - 1)) begin
        busy <= 1'b0;
      end
    end
  end

endmodule
